FILE: rtl/fod_pkg.sv
// ----------------------------------------------------------------------------
// fod_pkg
// types and constants for the fuzzy oversampling decision pipeline
// ----------------------------------------------------------------------------
package fod_pkg;

    typedef struct packed {
        logic [15:0] structure_size;
        logic [15:0] complexity;
        logic        measures_valid;
    } in_word_t;

    typedef struct packed {
        logic signed [2:0] factor_power;
        logic [3:0]        factor_halves;
    } out_word_t;

    localparam int NUM_RULES   = 6;
    localparam int NUM_STAGES  = 9;
    localparam int AREA_W      = 40;
    localparam int MOM_W       = 56;

    localparam logic [14:0] FX_ONE = 15'd16384;

    // size breakpoints, Q8.8
    localparam logic [15:0] SZ_7  = 16'd1792;
    localparam logic [15:0] SZ_12 = 16'd3072;
    localparam logic [15:0] SZ_14 = 16'd3584;
    localparam logic [15:0] SZ_18 = 16'd4608;
    localparam logic [15:0] SZ_36 = 16'd9216;
    localparam logic [15:0] SZ_72 = 16'd18432;

    // reciprocals for the divide by 5 and by 9 on the sloped segments
    localparam logic [13:0] RCP5 = 14'd13107;
    localparam logic [16:0] RCP9 = 17'd116508;

    // per rule coefficients: rules are vhigh, high, high, normal, normal, low
    localparam logic signed [15:0] AREA_LIN [NUM_RULES] = '{
        16'sd8, 16'sd12, 16'sd12, 16'sd12, 16'sd12, 16'sd12};
    localparam logic signed [15:0] AREA_SQR [NUM_RULES] = '{
        16'sd2, 16'sd4, 16'sd4, 16'sd6, 16'sd6, 16'sd4};
    localparam logic signed [15:0] MOM_LIN [NUM_RULES] = '{
        16'sd168, 16'sd144, 16'sd144, 16'sd0, 16'sd0, -16'sd72};
    localparam logic signed [15:0] MOM_SQR [NUM_RULES] = '{
        16'sd30, 16'sd48, 16'sd48, -16'sd18, -16'sd18, 16'sd12};
    localparam logic signed [15:0] MOM_CUB [NUM_RULES] = '{
        -16'sd4, 16'sd0, 16'sd0, -16'sd12, -16'sd12, 16'sd16};

    function automatic logic [14:0] min_q(input logic [14:0] x, input logic [14:0] y);
        return (x < y) ? x : y;
    endfunction

endpackage

FILE: rtl/fuzzy_oversampling_decision_top.sv
// ----------------------------------------------------------------------------
// fuzzy_oversampling_decision_top
// fuzzy inference of the oversampling power from structure size and complexity
// ----------------------------------------------------------------------------
// channel   ports                        word
// input     s_valid s_ready s_data       in_word_t  (size, complexity, valid)
// result    m_valid m_ready m_data       out_word_t (power, halves)
//
// one word per cycle sustained while the result channel is not stalled
// nine register stages: reciprocal products, quotient correction, rules,
// squares, cubes with area and moment terms, three adder levels, final compare
// aresetn clears the stage valid bits only
// each stage holds its word while the stage after it is full and stalled
// ----------------------------------------------------------------------------
module fuzzy_oversampling_decision_top import fod_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic [NUM_STAGES:1]   v_reg;
    logic [NUM_STAGES-1:0] v_in;
    logic [NUM_STAGES+1:1] en;

    always_comb begin
        en[NUM_STAGES+1] = m_ready;
        for (int i = NUM_STAGES; i >= 1; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign v_in    = {v_reg[NUM_STAGES-1:1], s_valid};
    assign s_ready = en[1];
    assign m_valid = v_reg[NUM_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 1; i <= NUM_STAGES; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_in[i-1];
                end
            end
        end
    end

    // stage 1: reciprocal products, complexity membership
    logic [15:0] diff5, diff9;
    logic [19:0] c10;
    logic [16:0] y5_next, y5_reg;
    logic [17:0] y9_next, y9_reg;
    logic [30:0] p5_next, p5_reg;
    logic [34:0] p9_next, p9_reg;
    logic [14:0] clow_next, clow1_reg;
    logic [15:0] s1_reg;
    logic        mv1_reg;

    always_comb begin
        diff5   = s_data.structure_size - SZ_7;
        diff9   = s_data.structure_size - SZ_36;
        y5_next = 17'({diff5[10:0], 6'd0}) + 17'd2;
        y9_next = 18'({diff9[13:0], 4'd0}) + 18'd4;
        p5_next = 31'(y5_next) * 31'(RCP5);
        p9_next = 35'(y9_next) * 35'(RCP9);
        c10     = 20'(s_data.complexity) * 20'd10;
        if (c10 >= 20'd24576) begin
            clow_next = '0;
        end else if (c10 <= 20'd8192) begin
            clow_next = FX_ONE;
        end else begin
            clow_next = 15'(20'd24576 - c10);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            y5_reg    <= y5_next;
            y9_reg    <= y9_next;
            p5_reg    <= p5_next;
            p9_reg    <= p9_next;
            clow1_reg <= clow_next;
            s1_reg    <= s_data.structure_size;
            mv1_reg   <= s_data.measures_valid;
        end
    end

    // stage 2: quotient correction
    logic [14:0] q5, q9, r5_next, r9_next, r5_reg, r9_reg, clow2_reg;
    logic [16:0] rem5;
    logic [17:0] rem9;
    logic [15:0] s2_reg;
    logic        mv2_reg;

    always_comb begin
        q5      = p5_reg[30:16];
        q9      = p9_reg[34:20];
        rem5    = y5_reg - 17'(q5) * 17'd5;
        rem9    = y9_reg - 18'(q9) * 18'd9;
        r5_next = (rem5 >= 17'd5) ? q5 + 15'd1 : q5;
        r9_next = (rem9 >= 18'd9) ? q9 + 15'd1 : q9;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            r5_reg    <= r5_next;
            r9_reg    <= r9_next;
            clow2_reg <= clow1_reg;
            s2_reg    <= s1_reg;
            mv2_reg   <= mv1_reg;
        end
    end

    // stage 3: size memberships and rule strengths
    logic [14:0] vsmall, small_m, medium_m, large_m, chigh;
    logic [14:0] h_next [NUM_RULES];
    logic [14:0] h_reg  [NUM_RULES];
    logic [15:0] s;

    always_comb begin
        s     = s2_reg;
        chigh = FX_ONE - clow2_reg;

        if (s <= SZ_7) begin
            vsmall = FX_ONE;
        end else if (s >= SZ_12) begin
            vsmall = '0;
        end else begin
            vsmall = FX_ONE - r5_reg;
        end

        if (s <= SZ_7 || s >= SZ_18) begin
            small_m = '0;
        end else if (s < SZ_12) begin
            small_m = r5_reg;
        end else if (s <= SZ_14) begin
            small_m = FX_ONE;
        end else begin
            small_m = 15'({SZ_18 - s, 4'd0});
        end

        if (s <= SZ_14 || s >= SZ_72) begin
            medium_m = '0;
        end else if (s < SZ_18) begin
            medium_m = 15'({s - SZ_14, 4'd0});
        end else if (s <= SZ_36) begin
            medium_m = FX_ONE;
        end else begin
            medium_m = FX_ONE - r9_reg;
        end

        if (s <= SZ_36) begin
            large_m = '0;
        end else if (s >= SZ_72) begin
            large_m = FX_ONE;
        end else begin
            large_m = r9_reg;
        end

        h_next[0] = vsmall;
        h_next[1] = min_q(small_m, chigh);
        h_next[2] = min_q(medium_m, chigh);
        h_next[3] = min_q(small_m, clow2_reg);
        h_next[4] = min_q(medium_m, clow2_reg);
        h_next[5] = large_m;
        if (!mv2_reg) begin
            for (int i = 0; i < NUM_RULES; i++) begin
                h_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            h_reg <= h_next;
        end
    end

    // stage 4: squares
    logic [28:0] sq_reg [NUM_RULES];
    logic [14:0] h4_reg [NUM_RULES];

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int i = 0; i < NUM_RULES; i++) begin
                sq_reg[i] <= 29'(h_reg[i]) * 29'(h_reg[i]);
                h4_reg[i] <= h_reg[i];
            end
        end
    end

    // stage 5: cubes, areas, moment terms in h and h^2
    logic [42:0]              cube_reg [NUM_RULES];
    logic signed [AREA_W-1:0] area_reg [NUM_RULES];
    logic signed [MOM_W-1:0]  mp_reg   [NUM_RULES];

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            for (int i = 0; i < NUM_RULES; i++) begin
                cube_reg[i] <= 43'(sq_reg[i]) * 43'(h4_reg[i]);
                area_reg[i] <= AREA_W'(
                    ((AREA_LIN[i] * $signed(64'(h4_reg[i]))) <<< 14)
                    - AREA_SQR[i] * $signed(64'(sq_reg[i])));
                mp_reg[i] <= MOM_W'(
                    ((MOM_LIN[i] * $signed(64'(h4_reg[i]))) <<< 28)
                    - ((MOM_SQR[i] * $signed(64'(sq_reg[i]))) <<< 14));
            end
        end
    end

    // stage 6: full moments, total area
    logic signed [MOM_W-1:0]  mom_reg [NUM_RULES];
    logic signed [AREA_W-1:0] area_tot_next, area_tot_reg;

    always_comb begin
        area_tot_next = '0;
        for (int i = 0; i < NUM_RULES; i++) begin
            area_tot_next = area_tot_next + area_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            for (int i = 0; i < NUM_RULES; i++) begin
                mom_reg[i] <= mp_reg[i]
                    + MOM_W'(MOM_CUB[i] * $signed(64'(cube_reg[i])));
            end
            area_tot_reg <= area_tot_next;
        end
    end

    // stage 7: moment pair sums, k = 3 * FX_ONE * area
    logic signed [MOM_W-1:0] mpair_reg [NUM_RULES/2];
    logic signed [MOM_W-1:0] k_reg, area_ext;
    logic                    pos7_reg;

    assign area_ext = MOM_W'(area_tot_reg);

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            for (int i = 0; i < NUM_RULES/2; i++) begin
                mpair_reg[i] <= mom_reg[2*i] + mom_reg[2*i+1];
            end
            k_reg    <= (area_ext <<< 15) + (area_ext <<< 14);
            pos7_reg <= area_tot_reg > 0;
        end
    end

    // stage 8: total moment and thresholds
    logic signed [MOM_W-1:0] mom_tot_reg, t2_reg, t6_reg;
    logic                    pos8_reg;

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            mom_tot_reg <= mpair_reg[0] + mpair_reg[1] + mpair_reg[2];
            t2_reg      <= k_reg <<< 1;
            t6_reg      <= (k_reg <<< 2) + (k_reg <<< 1);
            pos8_reg    <= pos7_reg;
        end
    end

    // stage 9: rounding compare, output word
    logic [1:0] cnt;
    out_word_t  out_next, out_reg;

    always_comb begin
        cnt = 2'(mom_tot_reg >= -t2_reg) + 2'(mom_tot_reg >= t2_reg)
            + 2'(mom_tot_reg >= t6_reg);
        if (pos8_reg) begin
            out_next.factor_power  = $signed(3'(cnt)) - 3'sd1;
            out_next.factor_halves = 4'd1 << cnt;
        end else begin
            out_next.factor_power  = 3'sd0;
            out_next.factor_halves = 4'd2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    a_halves_match : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.factor_halves
            == (4'd1 << 2'(m_data.factor_power + 3'sd1)))
        else $error("factor_halves does not match factor_power");

    a_full_when_blocked : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&v_reg[NUM_STAGES:1]) && !m_ready)
        else $error("input blocked while a stage is empty");

    a_heights_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[4] |-> (h4_reg[0] <= FX_ONE) && (h4_reg[1] <= FX_ONE)
            && (h4_reg[2] <= FX_ONE) && (h4_reg[3] <= FX_ONE)
            && (h4_reg[4] <= FX_ONE) && (h4_reg[5] <= FX_ONE))
        else $error("rule strength above one");

endmodule

FILE: dv/fuzzy_oversampling_decision_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_oversampling_decision_top_tb
// checks the oversampling power and factor words against an exact fuzzy
// inference predictor, under random idling on both channels and a long
// result stall that fills the pipeline
// ----------------------------------------------------------------------------
module fuzzy_oversampling_decision_top_tb import fod_pkg::*; ();

    localparam longint UNIT = 16384;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    in_word_t  pending_words[$];
    out_word_t expected_decisions[$];
    int        errors = 0;
    int        send_idle_pct = 6;
    int        recv_idle_pct = 82;
    int        hold_cycles = 0;

    fuzzy_oversampling_decision_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint ratio_q14(longint num, longint den);
        return (num * UNIT + den / 2) / den;
    endfunction

    function automatic longint lesser(longint x, longint y);
        return x < y ? x : y;
    endfunction

    // clipped trapezoid: left foot, left run, right foot, right run in quarters
    function automatic void add_trapezoid(input longint a, input longint r, input longint d,
                                          input longint f, input longint h,
                                          inout longint area, inout longint mom);
        area += 2 * (d - a) * h * UNIT - (r + f) * h * h;
        mom += 3 * (d * d - a * a) * h * UNIT * UNIT - 3 * (d * f + a * r) * h * h * UNIT
             + (f * f - r * r) * h * h * h;
    endfunction

    function automatic out_word_t predict_decision(in_word_t w);
        longint s, c, vsmall, sml, med, lrg, clow, chigh, t, area, mom, k;
        int p;
        out_word_t o;
        s = w.structure_size;
        c = w.complexity;
        p = 0;
        area = 0;
        mom = 0;
        if (w.measures_valid) begin
            if (s <= 1792) vsmall = UNIT;
            else if (s >= 3072) vsmall = 0;
            else vsmall = ratio_q14(3072 - s, 1280);
            if (s <= 1792 || s >= 4608) sml = 0;
            else if (s < 3072) sml = ratio_q14(s - 1792, 1280);
            else if (s <= 3584) sml = UNIT;
            else sml = ratio_q14(4608 - s, 1024);
            if (s <= 3584 || s >= 18432) med = 0;
            else if (s < 4608) med = ratio_q14(s - 3584, 1024);
            else if (s <= 9216) med = UNIT;
            else med = ratio_q14(18432 - s, 9216);
            if (s <= 9216) lrg = 0;
            else if (s >= 18432) lrg = UNIT;
            else lrg = ratio_q14(s - 9216, 9216);
            t = 24576 - 10 * c;
            clow = t < 0 ? 0 : (t > UNIT ? UNIT : t);
            chigh = UNIT - clow;
            add_trapezoid(5, 2, 9, 0, vsmall, area, mom);
            add_trapezoid(1, 2, 7, 2, lesser(sml, chigh), area, mom);
            add_trapezoid(1, 2, 7, 2, lesser(med, chigh), area, mom);
            add_trapezoid(-3, 4, 3, 2, lesser(sml, clow), area, mom);
            add_trapezoid(-3, 4, 3, 2, lesser(med, clow), area, mom);
            add_trapezoid(-5, 0, 1, 4, lrg, area, mom);
            if (area > 0) begin
                k = 3 * UNIT * area;
                p = -1;
                if (mom >= -2 * k) p++;
                if (mom >= 2 * k) p++;
                if (mom >= 6 * k) p++;
            end
        end
        o.factor_power = 3'(p);
        o.factor_halves = 4'(1 << (p + 1));
        return o;
    endfunction

    function automatic in_word_t make_word(int s, int c, bit v);
        in_word_t w;
        w.structure_size = 16'(s);
        w.complexity = 16'(c);
        w.measures_valid = v;
        return w;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (s_valid) expected_decisions = {expected_decisions, predict_decision(s_data)};
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data <= pending_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_decisions.size() == 0) begin
                $display("%0t unexpected word: actual %0d/%0d", $time,
                         m_data.factor_power, m_data.factor_halves);
                errors++;
            end else begin
                want = expected_decisions.pop_front();
                if (m_data.factor_power !== want.factor_power) begin
                    $display("%0t factor_power mismatch: expected %0d actual %0d", $time,
                             want.factor_power, m_data.factor_power);
                    errors++;
                end
                if (m_data.factor_halves !== want.factor_halves) begin
                    $display("%0t factor_halves mismatch: expected %0d actual %0d", $time,
                             want.factor_halves, m_data.factor_halves);
                    errors++;
                end
            end
        end
    end

    initial begin
        int sizes[14] = '{0, 1792, 1793, 2432, 3071, 3072, 3584, 4095, 4608, 9216,
                          13824, 18431, 18432, 65535};
        int cplx[7] = '{0, 1638, 1639, 2048, 2458, 2459, 65535};
        int s;
        int c;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (sizes[i]) pending_words = {pending_words, make_word(sizes[i], cplx[i % 7], 1'b1)};
        foreach (cplx[i]) pending_words = {pending_words, make_word(4000, cplx[i], 1'b1)};
        pending_words = {pending_words, make_word(65535, 65535, 1'b0)};
        pending_words = {pending_words, make_word(0, 0, 1'b0)};
        for (int i = 0; i < 825; i++) begin
            if (i == 280) send_idle_pct = 82;
            if (i == 280) recv_idle_pct = 6;
            if (i == 560) send_idle_pct = 0;
            if (i == 560) recv_idle_pct = 0;
            if (i == 700) hold_cycles = 200;
            case ($urandom_range(3))
                0: s = $urandom_range(65535);
                1: s = $urandom_range(20000);
                default: s = $urandom_range(1700, 5000);
            endcase
            c = $urandom_range(1) ? $urandom_range(65535) : $urandom_range(1400, 2700);
            pending_words = {pending_words, make_word(s, c, $urandom_range(9) != 0)};
            while (pending_words.size() > 8) @(posedge aclk);
        end
        while (pending_words.size() > 0 || s_valid) @(posedge aclk);
        while (expected_decisions.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule

FILE: files.f
rtl/fod_pkg.sv
rtl/fuzzy_oversampling_decision_top.sv
dv/fuzzy_oversampling_decision_top_tb.sv
